FILE: hw/rtl/brd_pkg.sv
// brd_pkg: shared types, constants and helper functions of the 5x5 bayer demosaic
// used by brd_line_store, brd_window, brd_kernel and bayer_rggb_demosaic_5x5
package brd_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_HEIGHT    = 16384;
  localparam int MIN_DIM       = 4;
  localparam int ROW_SLOTS     = 5;
  localparam int PIX_W         = 16;
  localparam int ROW_W         = 14;
  localparam int COL_OUT_W     = 12;
  localparam int FW_W          = 13;
  localparam int FH_W          = 15;
  localparam int POS_W         = 17;
  localparam int SUM_W         = 24;
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;

  // register index, taken from paddr bit 2
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [ROW_SLOTS-1:0][PIX_W-1:0] col_vec_t;
  typedef logic [ROW_SLOTS-1:0][ROW_SLOTS-1:0][PIX_W-1:0] win_t;

  // the thirteen samples that the four kernels touch
  typedef struct packed {
    pix_t c;
    pix_t n1;
    pix_t s1;
    pix_t w1;
    pix_t e1;
    pix_t n2;
    pix_t s2;
    pix_t w2;
    pix_t e2;
    pix_t nw;
    pix_t ne;
    pix_t sw;
    pix_t se;
  } brd_taps_t;

  typedef struct packed {
    logic [COL_OUT_W-1:0] col;
    logic [ROW_W-1:0]     row;
    logic                 last;
  } brd_site_t;

  // mirrored position relative to the oldest entry of the window
  function automatic logic [2:0] rel_idx(logic signed [POS_W-1:0] pos,
                                         logic signed [POS_W-1:0] n,
                                         logic signed [POS_W-1:0] cur);
    logic signed [POS_W-1:0] m;
    logic signed [POS_W-1:0] d;
    m = pos;
    if (m < 0) m = -m;
    if (m >= n) m = n + n - POS_W'(2) - m;
    d = m - cur + POS_W'(4);
    return d[2:0];
  endfunction

  function automatic pix_t pick5(col_vec_t v, logic [2:0] k);
    pix_t p;
    case (k)
      3'd0:    p = v[0];
      3'd1:    p = v[1];
      3'd2:    p = v[2];
      3'd3:    p = v[3];
      3'd4:    p = v[4];
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

FILE: hw/rtl/brd_line_store.sv
// brd_line_store: five row banks of raw samples, one write and one read per bank
// depends on brd_pkg
module brd_line_store
  import brd_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [2:0]                   wslot,
  input  logic [$clog2(MAX_WIDTH)-1:0] waddr,
  input  pix_t                         wdata,
  input  logic                         re,
  input  logic [$clog2(MAX_WIDTH)-1:0] raddr,
  output col_vec_t                     rdata
);

  col_vec_t rd_r;

  // one bank per row slot
  for (genvar b = 0; b < ROW_SLOTS; b++) begin : g_bank
    pix_t mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (we && (wslot == 3'(b))) begin
        mem[waddr] <= wdata;
      end
      if (re) begin
        rd_r[b] <= mem[raddr];
      end
    end
  end

  assign rdata = rd_r;

endmodule

FILE: hw/rtl/brd_window.sv
// brd_window: 5x5 sample window, site sequencer and mirrored tap gather
// depends on brd_pkg
module brd_window
  import brd_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         col_valid,
  output logic                         col_take,
  input  col_vec_t                     col_vec,
  input  logic [$clog2(MAX_WIDTH)-1:0] col_x,
  input  logic [ROW_W-1:0]             col_y,
  input  logic [$clog2(MAX_WIDTH):0]   eff_w,
  input  logic [FH_W-1:0]              eff_h,
  output logic                         tap_valid,
  input  logic                         tap_ready,
  output brd_taps_t                    taps,
  output brd_site_t                    site
);

  localparam int CW = $clog2(MAX_WIDTH);

  win_t             win_r;
  logic             busy_r, busy_nxt;
  logic [CW-1:0]    cur_x_r, cur_x_nxt, x0_r, x0_nxt, x1_r, x1_nxt, cen_x_r, cen_x_nxt;
  logic [ROW_W-1:0] cur_y_r, cur_y_nxt, y1_r, y1_nxt, cen_y_r, cen_y_nxt;
  logic             s3_v_r;
  brd_taps_t        taps_r, taps_nxt;
  brd_site_t        site_r, site_nxt;
  logic             room, emit, last;
  logic [2:0]       kr [5];
  logic [2:0]       kc [5];
  col_vec_t         rows [5];

  assign room     = !s3_v_r || tap_ready;
  assign emit     = busy_r && room;
  assign last     = (cur_x_r == x1_r) && (cur_y_r == y1_r);
  assign col_take = col_valid && (!busy_r || (emit && last));

  // site sequencer: sites of one request in raster order
  always_comb begin
    busy_nxt  = busy_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    x0_nxt    = x0_r;
    x1_nxt    = x1_r;
    y1_nxt    = y1_r;
    cen_x_nxt = cen_x_r;
    cen_y_nxt = cen_y_r;
    if (col_take) begin
      busy_nxt  = (col_x >= CW'(2)) && (col_y >= ROW_W'(2));
      x0_nxt    = col_x - CW'(2);
      x1_nxt    = ((CW+1)'(col_x) == eff_w - 1'b1) ? col_x : col_x - CW'(2);
      y1_nxt    = (FH_W'(col_y) == eff_h - 1'b1) ? col_y : col_y - ROW_W'(2);
      cur_x_nxt = col_x - CW'(2);
      cur_y_nxt = col_y - ROW_W'(2);
      cen_x_nxt = col_x;
      cen_y_nxt = col_y;
    end else if (emit) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else if (cur_x_r == x1_r) begin
        cur_x_nxt = x0_r;
        cur_y_nxt = cur_y_r + 1'b1;
      end else begin
        cur_x_nxt = cur_x_r + 1'b1;
      end
    end
  end

  // mirrored row and column offsets into the window
  always_comb begin
    for (int d = 0; d < 5; d++) begin
      kr[d] = rel_idx($signed(POS_W'(cur_y_r) + POS_W'(d) - POS_W'(2)),
                      $signed(POS_W'(eff_h)), $signed(POS_W'(cen_y_r)));
      kc[d] = rel_idx($signed(POS_W'(cur_x_r) + POS_W'(d) - POS_W'(2)),
                      $signed(POS_W'(eff_w)), $signed(POS_W'(cen_x_r)));
      rows[d] = '0;
    end
    for (int d = 0; d < 5; d++) begin
      case (kr[d])
        3'd0:    rows[d] = win_r[0];
        3'd1:    rows[d] = win_r[1];
        3'd2:    rows[d] = win_r[2];
        3'd3:    rows[d] = win_r[3];
        3'd4:    rows[d] = win_r[4];
        default: rows[d] = '0;
      endcase
    end
  end

  // gather the kernel taps; each rows[] entry is one window row, its samples ordered by column age
  always_comb begin
    taps_nxt.c  = pick5(rows[2], kc[2]);
    taps_nxt.n1 = pick5(rows[1], kc[2]);
    taps_nxt.s1 = pick5(rows[3], kc[2]);
    taps_nxt.n2 = pick5(rows[0], kc[2]);
    taps_nxt.s2 = pick5(rows[4], kc[2]);
    taps_nxt.w1 = pick5(rows[2], kc[1]);
    taps_nxt.e1 = pick5(rows[2], kc[3]);
    taps_nxt.w2 = pick5(rows[2], kc[0]);
    taps_nxt.e2 = pick5(rows[2], kc[4]);
    taps_nxt.nw = pick5(rows[1], kc[1]);
    taps_nxt.ne = pick5(rows[1], kc[3]);
    taps_nxt.sw = pick5(rows[3], kc[1]);
    taps_nxt.se = pick5(rows[3], kc[3]);
    site_nxt.col  = COL_OUT_W'(cur_x_r);
    site_nxt.row  = cur_y_r;
    site_nxt.last = last;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (room) begin
        s3_v_r <= emit;
      end
    end
  end

  // window shift and payload registers
  always_ff @(posedge clk) begin
    cur_x_r <= cur_x_nxt;
    cur_y_r <= cur_y_nxt;
    x0_r    <= x0_nxt;
    x1_r    <= x1_nxt;
    y1_r    <= y1_nxt;
    cen_x_r <= cen_x_nxt;
    cen_y_r <= cen_y_nxt;
    if (col_take) begin
      for (int r = 0; r < ROW_SLOTS; r++) begin
        for (int k = 0; k < ROW_SLOTS - 1; k++) begin
          win_r[r][k] <= win_r[r][k+1];
        end
        win_r[r][ROW_SLOTS-1] <= col_vec[r];
      end
    end
    if (emit) begin
      taps_r <= taps_nxt;
      site_r <= site_nxt;
    end
  end

  assign tap_valid = s3_v_r;
  assign taps      = taps_r;
  assign site      = site_r;

endmodule

FILE: hw/rtl/brd_kernel.sv
// brd_kernel: the four 5x5 interpolation kernels, clamp and result register
// depends on brd_pkg
module brd_kernel
  import brd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      tap_valid,
  output logic      tap_ready,
  input  brd_taps_t taps,
  input  brd_site_t site,
  output logic      out_valid,
  input  logic      out_stall,
  output pix_t      red,
  output pix_t      green,
  output pix_t      blue,
  output brd_site_t site_out
);

  logic             out_v_r;
  pix_t             red_r, green_r, blue_r;
  pix_t             red_nxt, green_nxt, blue_nxt;
  brd_site_t        site_r;
  logic signed [SUM_W-1:0] g_sum, h_sum, v_sum, x_sum;
  logic signed [SUM_W-1:0] ax1v, ax1h, ax2v, ax2h, dg, cc, ax2;
  pix_t             g_val, h_val, v_val, x_val;

  function automatic logic signed [SUM_W-1:0] ext(pix_t p);
    return $signed(SUM_W'(p));
  endfunction

  // floor shift and clamp to the pixel range
  function automatic pix_t clamp(logic signed [SUM_W-1:0] s, logic by16);
    logic signed [SUM_W-1:0] v;
    pix_t r;
    v = by16 ? (s >>> 4) : (s >>> 3);
    if (s <= 0) r = '0;
    else if (v > $signed(SUM_W'(16'hFFFF))) r = 16'hFFFF;
    else r = v[PIX_W-1:0];
    return r;
  endfunction

  assign tap_ready = !out_v_r || !out_stall;

  // kernel sums
  always_comb begin
    cc    = ext(taps.c);
    ax1v  = ext(taps.n1) + ext(taps.s1);
    ax1h  = ext(taps.w1) + ext(taps.e1);
    ax2v  = ext(taps.n2) + ext(taps.s2);
    ax2h  = ext(taps.w2) + ext(taps.e2);
    ax2   = ax2v + ax2h;
    dg    = ext(taps.nw) + ext(taps.ne) + ext(taps.sw) + ext(taps.se);
    g_sum = (cc <<< 2) + ((ax1v + ax1h) <<< 1) - ax2;
    h_sum = (cc <<< 3) + (cc <<< 1) + (ax1h <<< 3) - (ax2h <<< 1) - (dg <<< 1) + ax2v;
    v_sum = (cc <<< 3) + (cc <<< 1) + (ax1v <<< 3) - (ax2v <<< 1) - (dg <<< 1) + ax2h;
    x_sum = (cc <<< 3) + (cc <<< 2) + (dg <<< 2) - (ax2 <<< 1) - ax2;
    g_val = clamp(g_sum, 1'b0);
    h_val = clamp(h_sum, 1'b1);
    v_val = clamp(v_sum, 1'b1);
    x_val = clamp(x_sum, 1'b1);
  end

  // choose by bayer phase of the site
  always_comb begin
    case ({site.row[0], site.col[0]})
      2'b00: begin
        red_nxt = taps.c; green_nxt = g_val; blue_nxt = x_val;
      end
      2'b01: begin
        red_nxt = h_val; green_nxt = taps.c; blue_nxt = v_val;
      end
      2'b10: begin
        red_nxt = v_val; green_nxt = taps.c; blue_nxt = h_val;
      end
      default: begin
        red_nxt = x_val; green_nxt = g_val; blue_nxt = taps.c;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (tap_ready) begin
      out_v_r <= tap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tap_ready && tap_valid) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      site_r  <= site;
    end
  end

  assign out_valid = out_v_r;
  assign red       = red_r;
  assign green     = green_r;
  assign blue      = blue_r;
  assign site_out  = site_r;

endmodule

FILE: hw/rtl/bayer_rggb_demosaic_5x5.sv
// bayer_rggb_demosaic_5x5: top level with config registers, raster counters and input stage
// depends on brd_pkg, brd_line_store, brd_window, brd_kernel
//
// Streaming RGGB demosaic with the 5x5 Malvar-He-Cutler kernels. Raw samples are taken one per
// clock in raster order while in_stall is low; a site's RGB appears once sample (x+2, y+2) is
// in, with mirrored borders. Each sample normally yields one result, so the block runs at one
// sample per cycle while out_stall is low; from the third row on, the last sample of a row
// yields three results, as does every sample from the third column on in the last row, and the
// last sample of a frame yields nine. The input is stalled meanwhile, since the single site
// sequencer in the window stage emits one site per cycle, and only while the kernel has room.
// The first result of an accepted sample passes the input register with line store read, the
// window, the tap register and the kernel register. The first two rows and columns release nothing.
// Writing frame_width (0x0) or frame_height (0x4) restarts the frame; write only while idle.
module bayer_rggb_demosaic_5x5
  import brd_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     in_raw_pixel,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     out_red,
  output logic [PIX_W-1:0]     out_green,
  output logic [PIX_W-1:0]     out_blue,
  output logic [COL_OUT_W-1:0] out_col,
  output logic [ROW_W-1:0]     out_row,
  output logic                 out_last_of_run,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [FW_W-1:0]  width_r;
  logic [FH_W-1:0]  height_r;
  logic             cfg_we;
  logic [15:0]      fw16;
  logic [CW:0]      eff_w;
  logic [FH_W-1:0]  eff_h;
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [2:0]       slot_r, slot_nxt;
  logic             accept;
  logic             s1_v_r;
  pix_t             s1_pix_r;
  logic [CW-1:0]    s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [2:0]       s1_slot_r;
  col_vec_t         rd_data, col_vec;
  logic             col_take;
  logic             tap_valid, tap_ready;
  brd_taps_t        taps;
  brd_site_t        site, site_out;
  logic [3:0]       sidx;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_HEIGHT) ? DATA_W'(height_r) : DATA_W'(width_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= FW_W'(4096);
      height_r <= FH_W'(4096);
    end else if (cfg_we) begin
      if (paddr[2] == REG_WIDTH) width_r <= pwdata[FW_W-1:0];
      else                       height_r <= pwdata[FH_W-1:0];
    end
  end

  // clamp frame size to the supported range
  always_comb begin
    fw16 = 16'(width_r);
    if (fw16 < 16'(MIN_DIM))        fw16 = 16'(MIN_DIM);
    else if (fw16 > 16'(MAX_WIDTH)) fw16 = 16'(MAX_WIDTH);
    eff_w = fw16[CW:0];
    if (height_r < FH_W'(MIN_DIM))         eff_h = FH_W'(MIN_DIM);
    else if (height_r > FH_W'(MAX_HEIGHT)) eff_h = FH_W'(MAX_HEIGHT);
    else                                   eff_h = height_r;
  end

  // input request handshake
  assign in_stall = s1_v_r && !col_take;
  assign accept   = in_valid && !in_stall;

  // raster position and row slot of the next sample
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    slot_nxt = slot_r;
    if (cfg_we) begin
      col_nxt  = '0;
      row_nxt  = '0;
      slot_nxt = '0;
    end else if (accept) begin
      if ((CW+1)'(col_r) == eff_w - 1'b1) begin
        col_nxt = '0;
        if (FH_W'(row_r) == eff_h - 1'b1) begin
          row_nxt  = '0;
          slot_nxt = '0;
        end else begin
          row_nxt  = row_r + 1'b1;
          slot_nxt = (slot_r == 3'(ROW_SLOTS - 1)) ? 3'd0 : slot_r + 1'b1;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
      s1_v_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
      if (accept)        s1_v_r <= 1'b1;
      else if (col_take) s1_v_r <= 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= in_raw_pixel;
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
      s1_slot_r <= slot_r;
    end
  end

  brd_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_store (
    .clk   (clk),
    .we    (accept),
    .wslot (slot_r),
    .waddr (col_r),
    .wdata (in_raw_pixel),
    .re    (accept),
    .raddr (col_r),
    .rdata (rd_data)
  );

  // order the column oldest row first, current sample bypassed as the newest
  always_comb begin
    for (int k = 0; k < ROW_SLOTS - 1; k++) begin
      sidx = 4'(s1_slot_r) + 4'(k) + 4'd1;
      if (sidx >= 4'(ROW_SLOTS)) sidx = sidx - 4'(ROW_SLOTS);
      col_vec[k] = pick5(rd_data, sidx[2:0]);
    end
    col_vec[ROW_SLOTS-1] = s1_pix_r;
  end

  brd_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .col_valid (s1_v_r),
    .col_take  (col_take),
    .col_vec   (col_vec),
    .col_x     (s1_col_r),
    .col_y     (s1_row_r),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .tap_valid (tap_valid),
    .tap_ready (tap_ready),
    .taps      (taps),
    .site      (site)
  );

  brd_kernel u_kernel (
    .clk       (clk),
    .rst_n     (rst_n),
    .tap_valid (tap_valid),
    .tap_ready (tap_ready),
    .taps      (taps),
    .site      (site),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red       (out_red),
    .green     (out_green),
    .blue      (out_blue),
    .site_out  (site_out)
  );

  assign out_col         = site_out.col;
  assign out_row         = site_out.row;
  assign out_last_of_run = site_out.last;

endmodule

FILE: tb/sv/tb_bayer_rggb_demosaic_5x5.sv
// tb_bayer_rggb_demosaic_5x5: self-checking testbench of the 5x5 rggb demosaic
// depends on brd_pkg and bayer_rggb_demosaic_5x5; holds its own pixel-exact demosaic predictor
`timescale 1ns / 100ps

module tb_bayer_rggb_demosaic_5x5;
  import brd_pkg::*;

  typedef enum int {K_GREEN, K_HORZ, K_VERT, K_CROSS} kern_e;

  typedef struct {
    logic [PIX_W-1:0]     red;
    logic [PIX_W-1:0]     green;
    logic [PIX_W-1:0]     blue;
    logic [COL_OUT_W-1:0] col;
    logic [ROW_W-1:0]     row;
    logic                 last;
  } rgb_site_t;

  typedef struct {
    logic [PIX_W-1:0] pix;
    bit               flat;
    logic [PIX_W-1:0] flat_val;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [PIX_W-1:0]     in_raw_pixel;
  logic                 out_valid;
  logic                 out_stall;
  logic [PIX_W-1:0]     out_red;
  logic [PIX_W-1:0]     out_green;
  logic [PIX_W-1:0]     out_blue;
  logic [COL_OUT_W-1:0] out_col;
  logic [ROW_W-1:0]     out_row;
  logic                 out_last_of_run;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [DATA_W-1:0]    pwdata;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  bayer_rggb_demosaic_5x5 u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_raw_pixel(in_raw_pixel),
    .out_valid(out_valid), .out_stall(out_stall), .out_red(out_red),
    .out_green(out_green), .out_blue(out_blue), .out_col(out_col),
    .out_row(out_row), .out_last_of_run(out_last_of_run),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [PIX_W-1:0] line_mem [ROW_SLOTS][MAX_WIDTH_DEF];
  int unsigned      pos_col;
  int unsigned      pos_row;
  logic [FW_W-1:0]  reg_width;
  logic [FH_W-1:0]  reg_height;
  rgb_site_t        rgb_expected[$];
  int               err_count;
  bit               quiet_in;
  bit               quiet_out;

  int kern [4][5][5] = '{
    '{'{0,0,-1,0,0}, '{0,0,2,0,0}, '{-1,2,4,2,-1}, '{0,0,2,0,0}, '{0,0,-1,0,0}},
    '{'{0,0,1,0,0}, '{0,-2,0,-2,0}, '{-2,8,10,8,-2}, '{0,-2,0,-2,0}, '{0,0,1,0,0}},
    '{'{0,0,-2,0,0}, '{0,-2,8,-2,0}, '{1,0,10,0,1}, '{0,-2,8,-2,0}, '{0,0,-2,0,0}},
    '{'{0,0,-3,0,0}, '{0,4,0,4,0}, '{-3,0,12,0,-3}, '{0,4,0,4,0}, '{0,0,-3,0,0}}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5ms;
    $display("tb_bayer_rggb_demosaic_5x5: errors");
    $finish;
  end

  function automatic int fold_edge(int v, int n);
    int m;
    m = v;
    if (m < 0) m = -m;
    if (m >= n) m = 2 * n - 2 - m;
    if (m < 0) m = 0;
    if (m >= n) m = n - 1;
    return m;
  endfunction

  function automatic int sample_at(int x, int y, int w, int h);
    int mx;
    int my;
    mx = fold_edge(x, w);
    my = fold_edge(y, h);
    return int'(line_mem[my % ROW_SLOTS][mx]);
  endfunction

  // weighted 5x5 sum, floor shift, clamp to pixel range
  function automatic logic [PIX_W-1:0] kernel_out(kern_e k, int shift, int cx, int cy,
                                                  int w, int h);
    int acc;
    acc = 0;
    for (int dy = -2; dy <= 2; dy++)
      for (int dx = -2; dx <= 2; dx++)
        if (kern[k][dy+2][dx+2] != 0)
          acc += kern[k][dy+2][dx+2] * sample_at(cx + dx, cy + dy, w, h);
    if (acc <= 0) return '0;
    acc = acc >>> shift;
    return (acc > 65535) ? 16'hFFFF : PIX_W'(acc);
  endfunction

  function automatic rgb_site_t site_color(int x, int y, int w, int h);
    rgb_site_t s;
    logic [PIX_W-1:0] raw;
    raw = PIX_W'(sample_at(x, y, w, h));
    case ({y[0], x[0]})
      2'b00: begin
        s.red = raw; s.green = kernel_out(K_GREEN, 3, x, y, w, h);
        s.blue = kernel_out(K_CROSS, 4, x, y, w, h);
      end
      2'b01: begin
        s.red = kernel_out(K_HORZ, 4, x, y, w, h); s.green = raw;
        s.blue = kernel_out(K_VERT, 4, x, y, w, h);
      end
      2'b10: begin
        s.red = kernel_out(K_VERT, 4, x, y, w, h); s.green = raw;
        s.blue = kernel_out(K_HORZ, 4, x, y, w, h);
      end
      default: begin
        s.red = kernel_out(K_CROSS, 4, x, y, w, h);
        s.green = kernel_out(K_GREEN, 3, x, y, w, h); s.blue = raw;
      end
    endcase
    s.col = COL_OUT_W'(x);
    s.row = ROW_W'(y);
    s.last = 1'b0;
    return s;
  endfunction

  // store one accepted pixel and queue the sites it releases
  function automatic void demosaic_predict(logic [PIX_W-1:0] pix, bit flat,
                                           logic [PIX_W-1:0] flat_val);
    int w;
    int h;
    int c;
    int r;
    int x1;
    int y1;
    int first;
    rgb_site_t s;
    w = int'(reg_width);
    h = int'(reg_height);
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    if (h < MIN_DIM) h = MIN_DIM;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    if (pos_col >= w) pos_col = 0;
    if (pos_row >= h) pos_row = 0;
    c = pos_col;
    r = pos_row;
    line_mem[r % ROW_SLOTS][c] = pix;
    if (c >= 2 && r >= 2) begin
      x1 = (c == w - 1) ? c : c - 2;
      y1 = (r == h - 1) ? r : r - 2;
      first = rgb_expected.size();
      for (int y = r - 2; y <= y1; y++)
        for (int x = c - 2; x <= x1; x++) begin
          s = site_color(x, y, w, h);
          if (flat) begin
            s.red = flat_val; s.green = flat_val; s.blue = flat_val;
          end
          rgb_expected.push_back(s);
        end
      if (rgb_expected.size() > first) rgb_expected[$].last = 1'b1;
    end
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= h) pos_row = 0;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    rgb_site_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (rgb_expected.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result col %0d row %0d", out_col, out_row);
      end else begin
        e = rgb_expected.pop_front();
        if (out_red !== e.red || out_green !== e.green || out_blue !== e.blue ||
            out_col !== e.col || out_row !== e.row || out_last_of_run !== e.last) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch exp rgb %h %h %h @%0d,%0d l%0b got %h %h %h @%0d,%0d l%0b",
                     e.red, e.green, e.blue, e.col, e.row, e.last, out_red, out_green,
                     out_blue, out_col, out_row, out_last_of_run);
        end
      end
    end
  end

  // result side stalls
  initial begin
    int gap;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = quiet_out ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_pixel(logic [PIX_W-1:0] pix, bit flat, logic [PIX_W-1:0] flat_val);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_raw_pixel <= pix;
    do @(posedge clk); while (in_stall);
    demosaic_predict(pix, flat, flat_val);
  endtask

  // wait for all results and the pipeline tail, then write one register
  task automatic write_reg(logic idx, logic [DATA_W-1:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (rgb_expected.size() == 0);
    repeat (8) @(posedge clk);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_WIDTH) reg_width = val[FW_W-1:0];
    else reg_height = val[FH_W-1:0];
    pos_col = 0;
    pos_row = 0;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // stimulus
  initial begin
    stim_row_t   dir_tab[$];
    stim_row_t   t;
    int          phase_w[6]  = '{5, 3, 7, 8191, 6, 4};
    int          phase_h[6]  = '{7, 0, 5, 32767, 9, 16384};
    int          phase_n[6]  = '{35, 32, 70, 24, 78, 40};
    logic [15:0] edge_pix[16] = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                                  16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
                                  16'hAAAA, 16'h5555, 16'h0001, 16'h8000,
                                  16'hFFFF, 16'h0000, 16'h7FFF, 16'hFFFF};
    rst_n = 1'b0;
    in_valid = 1'b0; in_raw_pixel = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    err_count = 0;
    pos_col = 0; pos_row = 0;
    reg_width = FW_W'(4096); reg_height = FH_W'(4096);
    quiet_in = 1'b0; quiet_out = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: a flat full-scale 4x4 frame gives full scale everywhere,
    // then a 4x4 frame that opens with two rows of checkerboard extremes, through the predictor
    for (int i = 0; i < 16; i++) begin
      t.pix = 16'hFFFF; t.flat = 1'b1; t.flat_val = 16'hFFFF;
      dir_tab.push_back(t);
    end
    foreach (edge_pix[i]) begin
      t.pix = edge_pix[i]; t.flat = 1'b0; t.flat_val = '0;
      dir_tab.push_back(t);
    end
    write_reg(REG_WIDTH, 32'd4);
    write_reg(REG_HEIGHT, 32'd4);
    foreach (dir_tab[i]) send_pixel(dir_tab[i].pix, dir_tab[i].flat, dir_tab[i].flat_val);

    // random phases over several frame sizes, clamped extremes among them
    foreach (phase_w[p]) begin
      write_reg(REG_WIDTH, phase_w[p]);
      write_reg(REG_HEIGHT, phase_h[p]);
      quiet_in = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < phase_n[p]; i++) send_pixel(rand_pixel(), 1'b0, '0);
    end

    // drain
    @(negedge clk);
    in_valid <= 1'b0;
    wait (rgb_expected.size() == 0);
    repeat (20) @(posedge clk);
    if (err_count == 0 && rgb_expected.size() == 0)
      $display("tb_bayer_rggb_demosaic_5x5: clean");
    else
      $display("tb_bayer_rggb_demosaic_5x5: errors");
    $finish;
  end

endmodule

FILE: bayer_rggb_demosaic_5x5.f
hw/rtl/brd_pkg.sv
hw/rtl/brd_line_store.sv
hw/rtl/brd_window.sv
hw/rtl/brd_kernel.sv
hw/rtl/bayer_rggb_demosaic_5x5.sv
tb/sv/tb_bayer_rggb_demosaic_5x5.sv
